// ----- sv/quaternion_to_matrix_and_euler_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the quaternion conversion core
// Concurrent checks that drop out of synthesis builds
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_MATRIX_AND_EULER_CORE_MACROS_SVH
`define QUATERNION_TO_MATRIX_AND_EULER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define QME_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define QME_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define QME_ASSERT(label, clk, rst, prop, msg)
`define QME_NEVER(label, clk, rst, expr, msg)
`endif

`endif

// ----- sv/qme_pkg.sv -----
// ----------------------------------------------------------------------------
// qme_pkg
// Shared types and constants of the quaternion conversion core
// ----------------------------------------------------------------------------
package qme_pkg;

  // pairwise products of the four components
  typedef struct packed {
    logic signed [31:0] xx;
    logic signed [31:0] yy;
    logic signed [31:0] zz;
    logic signed [31:0] ww;
    logic signed [31:0] xy;
    logic signed [31:0] xz;
    logic signed [31:0] xw;
    logic signed [31:0] yz;
    logic signed [31:0] yw;
    logic signed [31:0] zw;
  } prod_t;

  localparam int QDEPTH = 2;

  // atan(2^-i) scaled so that 2^31 is pi
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

endpackage

// ----- sv/quaternion_to_matrix_and_euler_core.sv -----
// ----------------------------------------------------------------------------
// quaternion_to_matrix_and_euler_core
// Quaternion to 3x3 rotation matrix and XYZ Euler angles
// ----------------------------------------------------------------------------
// One quaternion in, one result out; a new quaternion can be taken every
// cycle while the output is not stalled. The path from input to output
// register runs through a product stage, a two-entry queue, a sum stage, a
// rounding stage, FRAC_BITS+1 square-root stages for the asin path, one stage
// per CORDIC step with the three angle lanes side by side, and the output
// register. Angles are binary angles, 32768 = pi; matrix entries are
// saturated Q2.14 (FRAC_BITS fraction bits).
module quaternion_to_matrix_and_euler_core #(
  parameter int FRAC_BITS    = 14,
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,   // quat_x, quat_y, quat_z, quat_w
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [191:0] m_axis_tdata    // rot_00..rot_22, angle_x, angle_y, angle_z
);

  logic           f_vld, f_rdy, q_vld, q_rdy;
  qme_pkg::prod_t f_data, q_data;

  qme_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .out_valid (f_vld),
    .out_ready (f_rdy),
    .out_data  (f_data)
  );

  qme_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_vld),
    .in_ready  (f_rdy),
    .in_data   (f_data),
    .out_valid (q_vld),
    .out_ready (q_rdy),
    .out_data  (q_data)
  );

  qme_back #(
    .FRAC_BITS    (FRAC_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_vld),
    .in_ready  (q_rdy),
    .in_data   (q_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

// ----- sv/qme_front.sv -----
// ----------------------------------------------------------------------------
// qme_front
// Takes in quaternions and registers the ten pairwise products
// ----------------------------------------------------------------------------
module qme_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [63:0]           in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output qme_pkg::prod_t        out_data
);

  logic           vld;
  qme_pkg::prod_t prod;
  qme_pkg::prod_t prod_next;
  logic signed [15:0] x, y, z, w;

  assign x = in_data[15:0];
  assign y = in_data[31:16];
  assign z = in_data[47:32];
  assign w = in_data[63:48];

  always_comb begin
    prod_next.xx = x * x;
    prod_next.yy = y * y;
    prod_next.zz = z * z;
    prod_next.ww = w * w;
    prod_next.xy = x * y;
    prod_next.xz = x * z;
    prod_next.xw = x * w;
    prod_next.yz = y * z;
    prod_next.yw = y * w;
    prod_next.zw = z * w;
  end

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;
  assign out_data  = prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
    if (in_ready && in_valid) begin
      prod <= prod_next;
    end
  end

endmodule

// ----- sv/qme_queue.sv -----
// ----------------------------------------------------------------------------
// qme_queue
// Short request queue between the product front and the back pipeline
// ----------------------------------------------------------------------------
`include "quaternion_to_matrix_and_euler_core_macros.svh"

module qme_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  qme_pkg::prod_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output qme_pkg::prod_t out_data
);

  localparam int PW = (qme_pkg::QDEPTH > 1) ? $clog2(qme_pkg::QDEPTH) : 1;
  localparam int CW = $clog2(qme_pkg::QDEPTH + 1);

  qme_pkg::prod_t  mem [qme_pkg::QDEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [CW-1:0]   cnt;
  logic            push, pop;

  assign in_ready  = cnt != CW'(qme_pkg::QDEPTH);
  assign out_valid = cnt != '0;
  assign out_data  = mem[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(qme_pkg::QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(qme_pkg::QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
    if (push) begin
      mem[wptr] <= in_data;
    end
  end

  `QME_NEVER(a_cnt_bound, clk, rst, cnt > CW'(qme_pkg::QDEPTH), "queue count overflow")
  `QME_ASSERT(a_cnt_up, clk, rst, push && !pop |=> cnt == $past(cnt) + 1'b1, "queue count lost a push")
  `QME_ASSERT(a_cnt_dn, clk, rst, pop && !push |=> cnt == $past(cnt) - 1'b1, "queue count lost a pop")

endmodule

// ----- sv/qme_back.sv -----
// ----------------------------------------------------------------------------
// qme_back
// Matrix rounding, square root and three CORDIC lanes, fully pipelined
// ----------------------------------------------------------------------------
module qme_back #(
  parameter int FRAC_BITS    = 14,
  parameter int CORDIC_STEPS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  qme_pkg::prod_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [191:0]   out_data
);

  localparam int F   = FRAC_BITS;
  localparam int SW  = (2 * F + 3 > 35) ? 2 * F + 3 : 35;
  localparam int VW  = SW + 3;
  localparam int R   = F + 1;
  localparam int RMW = R + 3;
  localparam int N   = CORDIC_STEPS;
  localparam int L   = R + N;
  localparam logic [2*R-1:0] ONE_SQ = (2 * R)'(1) << (2 * F);

  typedef struct packed {
    logic [8:0][15:0]     mat;
    logic                 s_pos;
    logic                 s_neg;
    logic [R-1:0]         s_small;
    logic [2*R-1:0]       n;
    logic [RMW-1:0]       rem;
    logic [R-1:0]         root;
    logic [2:0][VW-1:0]   vx;
    logic [2:0][VW-1:0]   vy;
    logic [2:0][31:0]     ang;
    logic [2:0]           zero;
  } pipe_t;

  function automatic logic signed [SW-1:0] rnd(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] t;
    t = v + (SW'(1) <<< (F - 1));
    return t >>> F;
  endfunction

  function automatic logic [15:0] sat16(input logic signed [SW-1:0] v);
    logic [15:0] r;
    if (v > $signed(SW'(32767))) begin
      r = 16'h7fff;
    end else if (v < $signed(-SW'(32768))) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  logic en;
  logic a_vld;
  logic signed [SW-1:0] a_mat [9];
  logic signed [SW-1:0] a_den [2];
  logic signed [SW-1:0] a_sarg;

  logic  vld [L+1];
  pipe_t st  [L+1];
  pipe_t nx  [L+1];

  logic        o_vld;
  logic [191:0] o_data;

  assign en        = !o_vld || out_ready;
  assign in_ready  = en;
  assign out_valid = o_vld;
  assign out_data  = o_data;

  // sums of products
  always_ff @(posedge clk) begin
    logic signed [SW-1:0] xx, yy, zz, ww, xy, xz, xw, yz, yw, zw, one2;
    xx = SW'(in_data.xx); yy = SW'(in_data.yy); zz = SW'(in_data.zz);
    ww = SW'(in_data.ww); xy = SW'(in_data.xy); xz = SW'(in_data.xz);
    xw = SW'(in_data.xw); yz = SW'(in_data.yz); yw = SW'(in_data.yw);
    zw = SW'(in_data.zw);
    one2 = SW'(1) <<< (2 * F);
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_valid;
    end
    if (en) begin
      a_mat[0] <= one2 - (yy <<< 1) - (zz <<< 1);
      a_mat[1] <= (xy <<< 1) - (zw <<< 1);
      a_mat[2] <= (xz <<< 1) + (yw <<< 1);
      a_mat[3] <= (xy <<< 1) + (zw <<< 1);
      a_mat[4] <= one2 - (xx <<< 1) - (zz <<< 1);
      a_mat[5] <= (yz <<< 1) - (xw <<< 1);
      a_mat[6] <= (xz <<< 1) - (yw <<< 1);
      a_mat[7] <= (yz <<< 1) + (xw <<< 1);
      a_mat[8] <= one2 - (xx <<< 1) - (yy <<< 1);
      a_den[0] <= ww - xx - yy + zz;
      a_den[1] <= ww + xx - yy - zz;
      a_sarg   <= (yw <<< 1) - (xz <<< 1);
    end
  end

  // rounding, asin argument, cordic set-up of the two atan2 lanes
  always_comb begin
    logic signed [SW-1:0] s;
    logic signed [SW-1:0] num;
    logic signed [SW-1:0] den;
    logic signed [R-1:0]  ss;
    logic signed [2*R-1:0] sq;
    nx[0] = '0;
    for (int i = 0; i < 9; i++) begin
      nx[0].mat[i] = sat16(rnd(a_mat[i]));
    end
    s = rnd(a_sarg);
    nx[0].s_pos   = s >= (SW'(1) <<< F);
    nx[0].s_neg   = s <= -(SW'(1) <<< F);
    ss            = s[R-1:0];
    nx[0].s_small = ss;
    sq            = ss * ss;
    nx[0].n       = ONE_SQ - sq;
    for (int l = 0; l < 2; l++) begin
      num = (l == 0) ? a_mat[7] : a_mat[3];
      den = a_den[l];
      nx[0].zero[2*l] = (num == '0) && (den == '0);
      if (den < 0) begin
        nx[0].vx[2*l]  = VW'(-den);
        nx[0].vy[2*l]  = VW'(-num);
        nx[0].ang[2*l] = 32'h8000_0000;
      end else begin
        nx[0].vx[2*l]  = VW'(den);
        nx[0].vy[2*l]  = VW'(num);
        nx[0].ang[2*l] = '0;
      end
    end
  end

  for (genvar p = 1; p <= L; p++) begin : g_pipe
    if (p <= R) begin : g_sqrt
      // one root bit per stage
      always_comb begin
        logic [RMW-1:0] rem2;
        logic [RMW-1:0] trial;
        nx[p] = st[p-1];
        rem2  = {st[p-1].rem[RMW-3:0], st[p-1].n[2*R-1:2*R-2]};
        trial = {1'b0, st[p-1].root, 2'b01};
        nx[p].n = st[p-1].n << 2;
        if (rem2 >= trial) begin
          nx[p].rem  = rem2 - trial;
          nx[p].root = {st[p-1].root[R-2:0], 1'b1};
        end else begin
          nx[p].rem  = rem2;
          nx[p].root = {st[p-1].root[R-2:0], 1'b0};
        end
      end
    end else begin : g_cordic
      localparam int I = p - R - 1;
      always_comb begin
        logic signed [VW-1:0] vxs, vys, dx, dy;
        logic [31:0] a;
        nx[p] = st[p-1];
        for (int l = 0; l < 3; l++) begin
          if (I == 0 && l == 1) begin
            vxs = $signed({{(VW-R){1'b0}}, st[p-1].root});
            vys = VW'($signed(st[p-1].s_small));
            a   = '0;
          end else begin
            vxs = $signed(st[p-1].vx[l]);
            vys = $signed(st[p-1].vy[l]);
            a   = st[p-1].ang[l];
          end
          dx = vys >>> I;
          dy = vxs >>> I;
          if (vys < 0) begin
            nx[p].vx[l]  = vxs - dx;
            nx[p].vy[l]  = vys + dy;
            nx[p].ang[l] = a - qme_pkg::ATAN_TAB[I];
          end else begin
            nx[p].vx[l]  = vxs + dx;
            nx[p].vy[l]  = vys - dy;
            nx[p].ang[l] = a + qme_pkg::ATAN_TAB[I];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p <= L; p++) begin
        vld[p] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= a_vld;
      for (int p = 1; p <= L; p++) begin
        vld[p] <= vld[p-1];
      end
    end
    if (en) begin
      for (int p = 0; p <= L; p++) begin
        st[p] <= nx[p];
      end
    end
  end

  // angle rounding and the asin clamps
  always_ff @(posedge clk) begin
    logic [31:0] t;
    logic signed [15:0] ag [3];
    for (int l = 0; l < 3; l++) begin
      t     = st[L].ang[l] + 32'h8000;
      ag[l] = st[L].zero[l] ? 16'sd0 : $signed(t[31:16]);
    end
    if (st[L].s_pos || ag[1] > 16'sd16384) begin
      ag[1] = 16'sd16384;
    end else if (st[L].s_neg || ag[1] < -16'sd16384) begin
      ag[1] = -16'sd16384;
    end
    if (rst) begin
      o_vld <= 1'b0;
    end else if (en) begin
      o_vld <= vld[L];
    end
    if (en) begin
      o_data <= {ag[2], ag[1], ag[0], st[L].mat};
    end
  end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Streams quaternions through the conversion core and compares every matrix
// and Euler angle result against a bit-exact fixed-point predictor
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC   = 14;
  localparam int STEPS  = 16;
  localparam int LAT    = FRAC + STEPS + 6;
  localparam int NRAND  = 1430;
  localparam int WDOG   = 2000;

  typedef logic [191:0] rot_euler_t;

  class result_board;
    rot_euler_t pending[$];
    int errors;

    static function longint fshift(longint v, int s);
      return v >>> s;
    endfunction

    static function longint rnd(longint v);
      return fshift(v + (64'sd1 <<< (FRAC - 1)), FRAC);
    endfunction

    static function logic [15:0] sat(longint v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
    endfunction

    static function longint isqrt(longint n);
      longint root, bit_v;
      root = 0;
      bit_v = 64'sd1 <<< 62;
      while (bit_v > n) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
        if (n >= root + bit_v) begin
          n = n - (root + bit_v);
          root = (root >> 1) + bit_v;
        end else begin
          root = root >> 1;
        end
        bit_v = bit_v >> 2;
      end
      return root;
    endfunction

    static function logic [15:0] vec_angle(longint num, longint den);
      logic [31:0] acc, tmp;
      longint vx, vy, dx, dy;
      acc = 0;
      vx = den;
      vy = num;
      if (num == 0 && den == 0) return 16'd0;
      if (vx < 0) begin
        vx = -vx;
        vy = -vy;
        acc = 32'h8000_0000;
      end
      for (int i = 0; i < STEPS; i++) begin
        dx = fshift(vy, i);
        dy = fshift(vx, i);
        if (vy < 0) begin
          vx -= dx; vy += dy; acc -= qme_pkg::ATAN_TAB[i];
        end else begin
          vx += dx; vy -= dy; acc += qme_pkg::ATAN_TAB[i];
        end
      end
      tmp = acc + 32'h8000;
      return tmp[31:16];
    endfunction

    static function rot_euler_t convert(logic [63:0] q);
      longint x, y, z, w, one2, oneq, s, c, ay;
      longint xx, yy, zz, ww, xy, xz, xw, yz, yw, zw;
      logic [15:0] r [12];
      logic [15:0] a;
      rot_euler_t res;
      x = longint'($signed(q[15:0]));
      y = longint'($signed(q[31:16]));
      z = longint'($signed(q[47:32]));
      w = longint'($signed(q[63:48]));
      one2 = 64'sd1 <<< (2 * FRAC);
      oneq = 64'sd1 <<< FRAC;
      xx = x*x; yy = y*y; zz = z*z; ww = w*w;
      xy = x*y; xz = x*z; xw = x*w; yz = y*z; yw = y*w; zw = z*w;
      r[0] = sat(rnd(one2 - 2*yy - 2*zz));
      r[1] = sat(rnd(2*xy - 2*zw));
      r[2] = sat(rnd(2*xz + 2*yw));
      r[3] = sat(rnd(2*xy + 2*zw));
      r[4] = sat(rnd(one2 - 2*xx - 2*zz));
      r[5] = sat(rnd(2*yz - 2*xw));
      r[6] = sat(rnd(2*xz - 2*yw));
      r[7] = sat(rnd(2*yz + 2*xw));
      r[8] = sat(rnd(one2 - 2*xx - 2*yy));
      r[9] = vec_angle(2*(yz + xw), ww - xx - yy + zz);
      s = rnd(2*(yw - xz));
      if (s >= oneq) ay = 16384;
      else if (s <= -oneq) ay = -16384;
      else begin
        c = isqrt(oneq*oneq - s*s);
        a = vec_angle(s, c);
        ay = longint'($signed(a));
        if (ay > 16384) ay = 16384;
        if (ay < -16384) ay = -16384;
      end
      r[10] = ay[15:0];
      r[11] = vec_angle(2*(xy + zw), ww + xx - yy - zz);
      for (int k = 0; k < 12; k++) res[16*k +: 16] = r[k];
      return res;
    endfunction

    function void note_request(logic [63:0] q);
      pending.push_back(convert(q));
    endfunction

    function void check_result(rot_euler_t got);
      rot_euler_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      for (int k = 0; k < 12; k++)
        if (want[16*k +: 16] !== got[16*k +: 16]) begin
          $display("%0t: field %0d expected %h actual %h", $time, k,
                   want[16*k +: 16], got[16*k +: 16]);
          errors++;
        end
    endfunction
  endclass

  logic clk, rst;
  logic s_axis_tvalid, s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [191:0] m_axis_tdata;
  result_board board;
  int idle_cycles;

  quaternion_to_matrix_and_euler_core #(.FRAC_BITS(FRAC), .CORDIC_STEPS(STEPS)) u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic logic [63:0] pack_quat(int x, int y, int z, int w);
    logic [15:0] a, b, c, d;
    a = 16'(x); b = 16'(y); c = 16'(z); d = 16'(w);
    return {d, c, b, a};
  endfunction

  // half small-component quaternions, the rest raw noise and extremes
  function automatic logic [63:0] random_quat();
    int mode;
    int c [4];
    mode = $urandom_range(0, 9);
    for (int k = 0; k < 4; k++) begin
      if (mode < 5) c[k] = $urandom_range(0, 16384) - 8192;
      else if (mode < 8) c[k] = $signed(16'($urandom));
      else c[k] = ($urandom_range(0, 1)) ? 32767 - $urandom_range(0, 3)
                                          : -32768 + $urandom_range(0, 3);
    end
    if (mode == 4) c[$urandom_range(0, 3)] = 16384 * ($urandom_range(0, 1) ? 1 : -1);
    return pack_quat(c[0], c[1], c[2], c[3]);
  endfunction

  task automatic send_request(logic [63:0] q);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= q;
    do @(posedge clk); while (!s_axis_tready);
    board.note_request(q);
  endtask

  // downstream stall pattern
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(negedge rst);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG) begin
      $display("quaternion_to_matrix_and_euler_core verification failed");
      $finish;
    end
  end

  initial begin
    board = new();
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // identity, axis half-turns, quarter turns, gimbal lock, zero, extremes
    send_request(pack_quat(0, 0, 0, 16384));
    send_request(pack_quat(16384, 0, 0, 0));
    send_request(pack_quat(0, 16384, 0, 0));
    send_request(pack_quat(0, 0, 16384, 0));
    send_request(pack_quat(0, 0, 0, -16384));
    send_request(pack_quat(11585, 0, 0, 11585));
    send_request(pack_quat(0, 11585, 0, 11585));
    send_request(pack_quat(0, -11585, 0, 11585));
    send_request(pack_quat(0, 0, 11585, 11585));
    send_request(pack_quat(8192, 8192, 8192, 8192));
    send_request(pack_quat(8192, -8192, 8192, 8192));
    send_request(pack_quat(0, 0, 0, 0));
    send_request(pack_quat(32767, 32767, 32767, 32767));
    send_request(pack_quat(-32768, -32768, -32768, -32768));
    send_request(pack_quat(-32768, 32767, -32768, 32767));
    send_request(pack_quat(32767, -32768, 0, 1));
    send_request(pack_quat(0, 0, 1, 0));
    send_request(pack_quat(-1, 0, 0, 0));
    send_request(pack_quat(0, 20000, 0, 20000));
    send_request(pack_quat(21845, 0, 0, 0));
    for (int n = 0; n < NRAND; n++) send_request(random_quat());
    s_axis_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
    if (board.errors == 0)
      $display("quaternion_to_matrix_and_euler_core verification clean");
    else
      $display("quaternion_to_matrix_and_euler_core verification failed");
    $finish;
  end
endmodule
